[hdl/irsl_pkg.sv]
// ----------------------------------------------------------------------------
// irsl_pkg
// Shared types, constants and coefficient table for the IR range smoothing
// and linearization block.
// ----------------------------------------------------------------------------
package irsl_pkg;

    // Default sizing of the sample path
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF   = 8;

    // Two sensor channels: 0 right, 1 left
    localparam int CHANNELS = 2;
    localparam int CH_W     = 1;

    // Configuration register widths and indexes
    localparam int ALPHA_W = 9;
    localparam int BRK_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_HIGH  = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET      = 9'd77;
    localparam logic [BRK_W-1:0]   RIGHT_LOW_RESET  = 10'd255;
    localparam logic [BRK_W-1:0]   RIGHT_HIGH_RESET = 10'd390;
    localparam logic [BRK_W-1:0]   LEFT_LOW_RESET   = 10'd190;
    localparam logic [BRK_W-1:0]   LEFT_HIGH_RESET  = 10'd370;

    // Smoothing weight is Q1.8
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam int ALPHA_FRAC = 8;
    localparam int ALPHA_HALF = 128;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_PRIME  = 1'b1;

    // Horner accumulator: Q.32, clamped to +-2^50
    localparam int ACC_W    = 52;
    localparam int ACC_LO_W = 26;
    localparam longint MUL_LIM = 64'sh4000_0000_0000_0000;
    localparam longint ACC_LIM = 64'sh0004_0000_0000_0000;

    // Final rounding from Q.32 to Q12.4
    localparam int ROUND_SHIFT = 28;
    localparam longint ROUND_HALF = 64'sh0000_0000_0800_0000;
    localparam int DIST_W   = 16;
    localparam int DIST_MAX = 32767;
    localparam int DIST_MIN = -32768;

    // Segment and Horner pass indexes
    localparam int SEG_W  = 2;
    localparam int ITER_W = 2;
    localparam logic [ITER_W-1:0] ITER_FIRST = 2'd1;
    localparam logic [ITER_W-1:0] ITER_LAST  = 2'd3;

    // Q.32 coefficients per segment, highest power first
    //   right low quadratic, right high quadratic, left cubic, left quadratic
    localparam logic signed [ACC_W-1:0] COEF_TAB [4][4] = '{
        '{ 52'sd0, 52'sd5702428, -52'sd3231466392, 52'sd506372907577 },
        '{ 52'sd0, 52'sd1997546, -52'sd1601825233, 52'sd321509011122 },
        '{ -52'sd399094, 52'sd189010129, -52'sd30477471042, 52'sd1764384934703 },
        '{ 52'sd0, 52'sd1347509, -52'sd1098548266, 52'sd222014830990 }
    };

    // Microprogram step counter
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_EMA1,
        OP_EMA2,
        OP_SEL,
        OP_MLO,
        OP_MHI,
        OP_MADD,
        OP_ROUND,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_BRANCH,
        SEQ_WAIT
    } seq_t;

    typedef enum logic [2:0] {
        FLG_NONE,
        FLG_START,
        FLG_OUT_RANGE,
        FLG_MORE,
        FLG_OUT_FREE
    } flag_t;

    typedef struct packed {
        op_t             op;
        seq_t            seq;
        flag_t           flag;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic out_range;
        logic more;
        logic out_free;
    } flags_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [BRK_W-1:0]   right_low;
        logic [BRK_W-1:0]   right_high;
        logic [BRK_W-1:0]   left_low;
        logic [BRK_W-1:0]   left_high;
    } cfg_t;

endpackage

[hdl/irsl_seq.sv]
// ----------------------------------------------------------------------------
// irsl_seq
// Microprogram sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module irsl_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  irsl_pkg::flags_t  flags,
    output irsl_pkg::ctrl_t   ctrl
);

    // Program step labels
    localparam logic [irsl_pkg::PC_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_EMA1  = 4'd1;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_EMA2  = 4'd2;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_SEL   = 4'd3;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_MLO   = 4'd4;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_MHI   = 4'd5;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_MADD  = 4'd6;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_ROUND = 4'd7;
    localparam logic [irsl_pkg::PC_W-1:0] STEP_EMIT  = 4'd8;

    logic [irsl_pkg::PC_W-1:0] pc_reg;
    logic [irsl_pkg::PC_W-1:0] pc_next;
    logic                      flag_sel;

    // Control store
    function automatic irsl_pkg::ctrl_t rom(input logic [irsl_pkg::PC_W-1:0] pc);
        irsl_pkg::ctrl_t w;
        w = '{irsl_pkg::OP_NOP, irsl_pkg::SEQ_GOTO, irsl_pkg::FLG_NONE, STEP_IDLE};
        unique case (pc)
            STEP_IDLE:  w = '{irsl_pkg::OP_IDLE, irsl_pkg::SEQ_WAIT,
                              irsl_pkg::FLG_START, STEP_EMA1};
            STEP_EMA1:  w = '{irsl_pkg::OP_EMA1, irsl_pkg::SEQ_NEXT,
                              irsl_pkg::FLG_NONE, STEP_IDLE};
            STEP_EMA2:  w = '{irsl_pkg::OP_EMA2, irsl_pkg::SEQ_NEXT,
                              irsl_pkg::FLG_NONE, STEP_IDLE};
            STEP_SEL:   w = '{irsl_pkg::OP_SEL, irsl_pkg::SEQ_BRANCH,
                              irsl_pkg::FLG_OUT_RANGE, STEP_EMIT};
            STEP_MLO:   w = '{irsl_pkg::OP_MLO, irsl_pkg::SEQ_NEXT,
                              irsl_pkg::FLG_NONE, STEP_IDLE};
            STEP_MHI:   w = '{irsl_pkg::OP_MHI, irsl_pkg::SEQ_NEXT,
                              irsl_pkg::FLG_NONE, STEP_IDLE};
            STEP_MADD:  w = '{irsl_pkg::OP_MADD, irsl_pkg::SEQ_BRANCH,
                              irsl_pkg::FLG_MORE, STEP_MLO};
            STEP_ROUND: w = '{irsl_pkg::OP_ROUND, irsl_pkg::SEQ_NEXT,
                              irsl_pkg::FLG_NONE, STEP_IDLE};
            STEP_EMIT:  w = '{irsl_pkg::OP_EMIT, irsl_pkg::SEQ_WAIT,
                              irsl_pkg::FLG_OUT_FREE, STEP_IDLE};
            default:    w = '{irsl_pkg::OP_NOP, irsl_pkg::SEQ_GOTO,
                              irsl_pkg::FLG_NONE, STEP_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl = rom(pc_reg);

    // Select the condition named by the control word
    always_comb begin
        unique case (ctrl.flag)
            irsl_pkg::FLG_START:     flag_sel = flags.start;
            irsl_pkg::FLG_OUT_RANGE: flag_sel = flags.out_range;
            irsl_pkg::FLG_MORE:      flag_sel = flags.more;
            irsl_pkg::FLG_OUT_FREE:  flag_sel = flags.out_free;
            default:                 flag_sel = 1'b0;
        endcase
    end

    // Advance, jump or hold the step counter
    always_comb begin
        unique case (ctrl.seq)
            irsl_pkg::SEQ_NEXT:   pc_next = pc_reg + 1'b1;
            irsl_pkg::SEQ_GOTO:   pc_next = ctrl.target;
            irsl_pkg::SEQ_BRANCH: pc_next = flag_sel ? ctrl.target : pc_reg + 1'b1;
            irsl_pkg::SEQ_WAIT:   pc_next = flag_sel ? ctrl.target : pc_reg;
            default:              pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[hdl/irsl_dp.sv]
// ----------------------------------------------------------------------------
// irsl_dp
// Datapath driven by the control word: filter stages, segment select,
// split Horner multiplier, rounding and the output register.
// ----------------------------------------------------------------------------
module irsl_dp #(
    parameter int SAMPLE_BITS = irsl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = irsl_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  irsl_pkg::ctrl_t                        ctrl,
    input  irsl_pkg::cfg_t                         cfg,
    input  logic                                   s_fire,
    input  logic                                   in_kind,
    input  logic [irsl_pkg::CH_W-1:0]              in_channel,
    input  logic [SAMPLE_BITS-1:0]                 in_sample,
    input  logic                                   m_ready,
    output irsl_pkg::flags_t                       flags,
    output logic                                   m_valid,
    output logic [irsl_pkg::CH_W-1:0]              out_channel,
    output logic signed [irsl_pkg::DIST_W-1:0]     distance,
    output logic                                   in_range,
    output logic [SAMPLE_BITS-1:0]                 raw_echo,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0]       smoothed
);

    localparam int STAGE_W = SAMPLE_BITS + FRAC_BITS;
    localparam int DIFF_W  = STAGE_W + 1;
    localparam int EPROD_W = DIFF_W + irsl_pkg::ALPHA_W + 1;
    localparam int ACC_W   = irsl_pkg::ACC_W;
    localparam int LO_W    = irsl_pkg::ACC_LO_W;
    localparam int HI_W    = ACC_W - LO_W;
    localparam int PLO_W   = LO_W + STAGE_W;
    localparam int PHI_W   = HI_W + STAGE_W + 1;
    localparam int PROD_W  = PHI_W + LO_W;
    localparam int CMP_W   = STAGE_W + irsl_pkg::BRK_W;
    localparam int WIDE_W  = 64;

    localparam logic signed [PROD_W-1:0] MUL_HI_P = PROD_W'(irsl_pkg::MUL_LIM);
    localparam logic signed [PROD_W-1:0] MUL_LO_P = -MUL_HI_P;
    localparam logic signed [WIDE_W-1:0] MUL_HI_W = irsl_pkg::MUL_LIM;
    localparam logic signed [WIDE_W-1:0] MUL_LO_W = -irsl_pkg::MUL_LIM;
    localparam logic signed [WIDE_W-1:0] ACC_HI_W = irsl_pkg::ACC_LIM;
    localparam logic signed [WIDE_W-1:0] ACC_LO_W = -irsl_pkg::ACC_LIM;
    localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(irsl_pkg::ROUND_HALF);
    localparam logic signed [ACC_W-1:0]  D_MAX    = ACC_W'(irsl_pkg::DIST_MAX);
    localparam logic signed [ACC_W-1:0]  D_MIN    = ACC_W'(irsl_pkg::DIST_MIN);
    localparam logic signed [EPROD_W-1:0] EMA_HALF = EPROD_W'(irsl_pkg::ALPHA_HALF);

    // Filter state per channel
    logic [STAGE_W-1:0] first_reg  [irsl_pkg::CHANNELS];
    logic [STAGE_W-1:0] second_reg [irsl_pkg::CHANNELS];

    // Working registers
    logic [irsl_pkg::CH_W-1:0]    ch_reg;
    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic [STAGE_W-1:0]           x_reg;
    logic [irsl_pkg::SEG_W-1:0]   seg_reg;
    logic [irsl_pkg::ITER_W-1:0]  iter_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic [PLO_W-1:0]             plo_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [irsl_pkg::DIST_W-1:0] dist_reg;
    logic                         ok_reg;

    // Output register
    logic                               m_valid_reg;
    logic [irsl_pkg::CH_W-1:0]          out_ch_reg;
    logic signed [irsl_pkg::DIST_W-1:0] out_dist_reg;
    logic                               out_ok_reg;
    logic [SAMPLE_BITS-1:0]             out_raw_reg;
    logic [STAGE_W-1:0]                 out_x_reg;

    // Filter step signals
    logic [irsl_pkg::ALPHA_W-1:0] alpha_eff;
    logic [STAGE_W-1:0]           ema_in;
    logic [STAGE_W-1:0]           ema_old;
    logic signed [DIFF_W-1:0]     ema_diff;
    logic signed [EPROD_W-1:0]    ema_prod;
    logic signed [EPROD_W-1:0]    ema_step;
    logic signed [EPROD_W-1:0]    ema_sum;
    logic [STAGE_W-1:0]           ema_new;
    logic [STAGE_W-1:0]           prime_val;

    // Segment select signals
    logic [irsl_pkg::BRK_W-1:0]   brk_low;
    logic [irsl_pkg::BRK_W-1:0]   brk_high;
    logic                         le_low;
    logic                         le_high;

    // Horner step signals
    logic [PLO_W-1:0]             plo_calc;
    logic signed [PHI_W-1:0]      phi_calc;
    logic signed [PROD_W-1:0]     prod_calc;
    logic signed [WIDE_W-1:0]     prod_clamp;
    logic signed [WIDE_W-1:0]     prod_shift;
    logic signed [ACC_W-1:0]      coef;
    logic signed [WIDE_W-1:0]     madd_sum;
    logic signed [ACC_W-1:0]      madd_next;

    // Rounding signals
    logic signed [ACC_W-1:0]      rnd_sum;
    logic signed [ACC_W-1:0]      rnd_q;
    logic signed [irsl_pkg::DIST_W-1:0] rnd_sat;

    logic out_free;

    // Exponential filter: s + ((a * (in - s) + half) >> 8), one multiplier shared
    always_comb begin
        alpha_eff = (cfg.alpha > irsl_pkg::ALPHA_ONE) ? irsl_pkg::ALPHA_ONE : cfg.alpha;
        prime_val = {sample_reg, {FRAC_BITS{1'b0}}};
        if (ctrl.op == irsl_pkg::OP_EMA2) begin
            ema_in  = first_reg[ch_reg];
            ema_old = second_reg[ch_reg];
        end else begin
            ema_in  = prime_val;
            ema_old = first_reg[ch_reg];
        end
        ema_diff = $signed({1'b0, ema_in}) - $signed({1'b0, ema_old});
        ema_prod = $signed({1'b0, alpha_eff}) * ema_diff;
        ema_step = (ema_prod + EMA_HALF) >>> irsl_pkg::ALPHA_FRAC;
        ema_sum  = ema_step + $signed({{(EPROD_W - STAGE_W){1'b0}}, ema_old});
        ema_new  = ema_sum[STAGE_W-1:0];
    end

    // Breakpoint compare against the channel's Q.FRAC thresholds
    always_comb begin
        brk_low  = (ch_reg != '0) ? cfg.left_low  : cfg.right_low;
        brk_high = (ch_reg != '0) ? cfg.left_high : cfg.right_high;
        le_low   = CMP_W'(x_reg) <= CMP_W'({brk_low,  {FRAC_BITS{1'b0}}});
        le_high  = CMP_W'(x_reg) <= CMP_W'({brk_high, {FRAC_BITS{1'b0}}});
    end

    // Accumulator times x in two partial products
    always_comb begin
        plo_calc  = PLO_W'(acc_reg[LO_W-1:0]) * PLO_W'(x_reg);
        phi_calc  = $signed(acc_reg[ACC_W-1:LO_W]) * $signed({1'b0, x_reg});
        prod_calc = $signed({phi_calc, {LO_W{1'b0}}})
                  + $signed({{(PROD_W - PLO_W){1'b0}}, plo_reg});
    end

    // Clamp product, floor shift, add next coefficient, clamp accumulator
    always_comb begin
        if (prod_reg > MUL_HI_P) begin
            prod_clamp = MUL_HI_W;
        end else if (prod_reg < MUL_LO_P) begin
            prod_clamp = MUL_LO_W;
        end else begin
            prod_clamp = prod_reg[WIDE_W-1:0];
        end
        prod_shift = prod_clamp >>> FRAC_BITS;
        coef       = irsl_pkg::COEF_TAB[seg_reg][iter_reg];
        madd_sum   = prod_shift + $signed({{(WIDE_W - ACC_W){coef[ACC_W-1]}}, coef});
        if (madd_sum > ACC_HI_W) begin
            madd_next = ACC_HI_W[ACC_W-1:0];
        end else if (madd_sum < ACC_LO_W) begin
            madd_next = ACC_LO_W[ACC_W-1:0];
        end else begin
            madd_next = madd_sum[ACC_W-1:0];
        end
    end

    // Round half up to Q12.4 and saturate
    always_comb begin
        rnd_sum = acc_reg + RND_HALF;
        rnd_q   = rnd_sum >>> irsl_pkg::ROUND_SHIFT;
        if (rnd_q > D_MAX) begin
            rnd_sat = D_MAX[irsl_pkg::DIST_W-1:0];
        end else if (rnd_q < D_MIN) begin
            rnd_sat = D_MIN[irsl_pkg::DIST_W-1:0];
        end else begin
            rnd_sat = rnd_q[irsl_pkg::DIST_W-1:0];
        end
    end

    // Status to the sequencer
    assign out_free        = !m_valid_reg || m_ready;
    assign flags.start     = s_fire && (in_kind == irsl_pkg::KIND_SAMPLE);
    assign flags.out_range = !le_low && !le_high;
    assign flags.more      = iter_reg != irsl_pkg::ITER_LAST;
    assign flags.out_free  = out_free;

    // Filter state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < irsl_pkg::CHANNELS; i++) begin
                first_reg[i]  <= '0;
                second_reg[i] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            unique case (ctrl.op)
                irsl_pkg::OP_IDLE: begin
                    if (s_fire && in_kind == irsl_pkg::KIND_PRIME) begin
                        first_reg[in_channel]  <= {in_sample, {FRAC_BITS{1'b0}}};
                        second_reg[in_channel] <= {in_sample, {FRAC_BITS{1'b0}}};
                    end
                end
                irsl_pkg::OP_EMA1: first_reg[ch_reg]  <= ema_new;
                irsl_pkg::OP_EMA2: second_reg[ch_reg] <= ema_new;
                default: ;
            endcase
            // Load on emit, drop once taken
            if (ctrl.op == irsl_pkg::OP_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            irsl_pkg::OP_IDLE: begin
                if (s_fire) begin
                    ch_reg     <= in_channel;
                    sample_reg <= in_sample;
                end
            end
            irsl_pkg::OP_EMA2: x_reg <= ema_new;
            irsl_pkg::OP_SEL: begin
                seg_reg  <= {ch_reg, !le_low};
                iter_reg <= irsl_pkg::ITER_FIRST;
                acc_reg  <= irsl_pkg::COEF_TAB[{ch_reg, !le_low}][0];
                ok_reg   <= le_low || le_high;
                dist_reg <= '0;
            end
            irsl_pkg::OP_MLO:   plo_reg  <= plo_calc;
            irsl_pkg::OP_MHI:   prod_reg <= prod_calc;
            irsl_pkg::OP_MADD: begin
                acc_reg  <= madd_next;
                iter_reg <= iter_reg + 1'b1;
            end
            irsl_pkg::OP_ROUND: dist_reg <= rnd_sat;
            irsl_pkg::OP_EMIT: begin
                if (out_free) begin
                    out_ch_reg   <= ch_reg;
                    out_dist_reg <= dist_reg;
                    out_ok_reg   <= ok_reg;
                    out_raw_reg  <= sample_reg;
                    out_x_reg    <= x_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign out_channel = out_ch_reg;
    assign distance    = out_dist_reg;
    assign in_range    = out_ok_reg;
    assign raw_echo    = out_raw_reg;
    assign smoothed    = out_x_reg;

endmodule

[hdl/ir_range_smooth_linearize.sv]
// ----------------------------------------------------------------------------
// ir_range_smooth_linearize
// Two-channel IR range smoothing and piecewise polynomial linearization.
// ----------------------------------------------------------------------------
// A prime item (tuser kind 1) loads both filter stages of its channel with the
// sample and gives no result. A sample item runs two cascaded exponential
// filters, picks a polynomial segment from the channel's breakpoints and
// returns one result with a Q12.4 distance; above the upper breakpoint the
// distance is 0 and in_range is 0. Work is done by a microprogram; the two
// filter steps share one multiplier. A sample item stalls the input through
// the filter steps, segment select, three Horner passes of three steps each,
// rounding and emit; out of range it skips Horner and rounding. A prime item
// does not stall the input. A finished result waits in the output register
// while the next item is taken. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module ir_range_smooth_linearize #(
    parameter int SAMPLE_BITS = irsl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = irsl_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // sample
    input  logic [1:0]                             s_tuser,   // kind, channel
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // distance, raw_echo, smoothed
    output logic [((16 + 2 * SAMPLE_BITS + FRAC_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]                             m_tuser,   // out_channel, in_range
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [irsl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [irsl_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int STAGE_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int OUT_BITS = irsl_pkg::DIST_W + SAMPLE_BITS + STAGE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    irsl_pkg::ctrl_t  ctrl;
    irsl_pkg::flags_t flags;
    irsl_pkg::cfg_t   cfg_reg;
    irsl_pkg::cfg_t   cfg_next;

    logic                               s_fire;
    logic [irsl_pkg::CH_W-1:0]          out_channel;
    logic signed [irsl_pkg::DIST_W-1:0] distance;
    logic                               in_range;
    logic [SAMPLE_BITS-1:0]             raw_echo;
    logic [STAGE_W-1:0]                 smoothed;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                irsl_pkg::CFG_ALPHA:      cfg_next.alpha      = cfg_data[irsl_pkg::ALPHA_W-1:0];
                irsl_pkg::CFG_RIGHT_LOW:  cfg_next.right_low  = cfg_data[irsl_pkg::BRK_W-1:0];
                irsl_pkg::CFG_RIGHT_HIGH: cfg_next.right_high = cfg_data[irsl_pkg::BRK_W-1:0];
                irsl_pkg::CFG_LEFT_LOW:   cfg_next.left_low   = cfg_data[irsl_pkg::BRK_W-1:0];
                irsl_pkg::CFG_LEFT_HIGH:  cfg_next.left_high  = cfg_data[irsl_pkg::BRK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha      <= irsl_pkg::ALPHA_RESET;
            cfg_reg.right_low  <= irsl_pkg::RIGHT_LOW_RESET;
            cfg_reg.right_high <= irsl_pkg::RIGHT_HIGH_RESET;
            cfg_reg.left_low   <= irsl_pkg::LEFT_LOW_RESET;
            cfg_reg.left_high  <= irsl_pkg::LEFT_HIGH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Take an item only in the idle step of the program
    assign s_tready = (ctrl.op == irsl_pkg::OP_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    irsl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    irsl_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .s_fire      (s_fire),
        .in_kind     (s_tuser[0]),
        .in_channel  (s_tuser[1]),
        .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .m_ready     (m_tready),
        .flags       (flags),
        .m_valid     (m_tvalid),
        .out_channel (out_channel),
        .distance    (distance),
        .in_range    (in_range),
        .raw_echo    (raw_echo),
        .smoothed    (smoothed)
    );

    // Pack result fields, first field lowest
    assign m_tdata = OUT_W'({smoothed, raw_echo, distance});
    assign m_tuser = {in_range, out_channel};

    // A new result appears only out of the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctrl.op == irsl_pkg::OP_EMIT))
        else $error("result valid rose outside the emit step");

    // An out-of-range result carries a zero distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[15:0] == '0))
        else $error("out-of-range result with nonzero distance");

    // An accepted sample item starts the first filter step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == irsl_pkg::KIND_SAMPLE)
            |=> (ctrl.op == irsl_pkg::OP_EMA1))
        else $error("sample item did not start the filter");

endmodule
